// ===== rtl/i2cmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbs_pkg
// Shared types, constants and the microcode ROM of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

    localparam int BYTE_BITS = 8;
    localparam int BIT_CW    = $clog2(BYTE_BITS);
    localparam int UC_AW     = 5;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam int WAIT_W    = 16;

    localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(144);
    localparam logic [WAIT_W-1:0] WAIT_MIN   = WAIT_W'(1);

    // register index taken from paddr
    localparam logic [CFG_AW-3:0] REG_WAIT_CYCLES = '0;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_STOP    = 3'd1,
        OP_WRITE   = 3'd2,
        OP_READ    = 3'd3,
        OP_WAITACK = 3'd4,
        OP_ACK     = 3'd5,
        OP_NACK    = 3'd6,
        OP_NONE    = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        SCL_KEEP,
        SCL_LO,
        SCL_HI
    } t_scl_op;

    typedef enum logic [1:0] {
        SDA_KEEP,
        SDA_LO,
        SDA_HI,
        SDA_BIT
    } t_sda_op;

    typedef enum logic [1:0] {
        OWN_KEEP,
        OWN_SET,
        OWN_CLR
    } t_own_op;

    typedef struct packed {
        t_scl_op          scl;
        t_sda_op          sda;
        t_own_op          own;
        logic             wait_after;
        logic             last;
        logic             shift_clr;
        logic             shift_in;
        logic             rd_out;
        logic             ack_out;
        logic             loop;      // per-bit loop end: jump back until last bit
        logic [UC_AW-1:0] target;
    } t_ucode;

    // program entry points
    localparam logic [UC_AW-1:0] UC_START   = UC_AW'(0);
    localparam logic [UC_AW-1:0] UC_STOP    = UC_AW'(4);
    localparam logic [UC_AW-1:0] UC_WRITE   = UC_AW'(8);
    localparam logic [UC_AW-1:0] UC_READ    = UC_AW'(12);
    localparam logic [UC_AW-1:0] UC_WAITACK = UC_AW'(15);
    localparam logic [UC_AW-1:0] UC_ACK     = UC_AW'(18);
    localparam logic [UC_AW-1:0] UC_NACK    = UC_AW'(22);

    function automatic logic [UC_AW-1:0] f_entry(input t_opcode op);
        logic [UC_AW-1:0] a;
        case (op)
            OP_START:   a = UC_START;
            OP_STOP:    a = UC_STOP;
            OP_WRITE:   a = UC_WRITE;
            OP_READ:    a = UC_READ;
            OP_WAITACK: a = UC_WAITACK;
            OP_ACK:     a = UC_ACK;
            OP_NACK:    a = UC_NACK;
            default:    a = UC_START;
        endcase
        return a;
    endfunction

    function automatic t_ucode f_ucode(input logic [UC_AW-1:0] a);
        t_ucode u;
        u.scl        = SCL_KEEP;
        u.sda        = SDA_KEEP;
        u.own        = OWN_KEEP;
        u.wait_after = 1'b0;
        u.last       = 1'b0;
        u.shift_clr  = 1'b0;
        u.shift_in   = 1'b0;
        u.rd_out     = 1'b0;
        u.ack_out    = 1'b0;
        u.loop       = 1'b0;
        u.target     = '0;
        case (a)
            // start
            UC_AW'(0):  begin u.own = OWN_SET; u.sda = SDA_HI; end
            UC_AW'(1):  begin u.scl = SCL_HI; u.wait_after = 1'b1; end
            UC_AW'(2):  begin u.sda = SDA_LO; u.wait_after = 1'b1; end
            UC_AW'(3):  begin u.scl = SCL_LO; u.last = 1'b1; end
            // stop
            UC_AW'(4):  begin u.own = OWN_SET; u.sda = SDA_LO; end
            UC_AW'(5):  begin u.scl = SCL_LO; u.wait_after = 1'b1; end
            UC_AW'(6):  begin u.scl = SCL_HI; u.wait_after = 1'b1; end
            UC_AW'(7):  begin u.sda = SDA_HI; u.last = 1'b1; end
            // write
            UC_AW'(8):  begin u.own = OWN_SET; u.scl = SCL_LO; u.wait_after = 1'b1; end
            UC_AW'(9):  begin u.sda = SDA_BIT; u.wait_after = 1'b1; end
            UC_AW'(10): begin u.scl = SCL_HI; u.wait_after = 1'b1; end
            UC_AW'(11): begin
                u.scl    = SCL_LO;
                u.loop   = 1'b1;
                u.target = UC_AW'(9);
            end
            // read
            UC_AW'(12): begin u.own = OWN_CLR; u.shift_clr = 1'b1; u.wait_after = 1'b1; end
            UC_AW'(13): begin u.scl = SCL_HI; u.wait_after = 1'b1; end
            UC_AW'(14): begin
                u.scl      = SCL_LO;
                u.shift_in = 1'b1;
                u.rd_out   = 1'b1;
                u.loop     = 1'b1;
                u.target   = UC_AW'(13);
            end
            // wait for ack
            UC_AW'(15): begin u.own = OWN_CLR; u.sda = SDA_HI; end
            UC_AW'(16): begin u.scl = SCL_HI; u.wait_after = 1'b1; end
            UC_AW'(17): begin u.scl = SCL_LO; u.ack_out = 1'b1; u.last = 1'b1; end
            // ack
            UC_AW'(18): begin u.own = OWN_SET; u.scl = SCL_LO; end
            UC_AW'(19): begin u.sda = SDA_LO; u.wait_after = 1'b1; end
            UC_AW'(20): begin u.scl = SCL_HI; u.wait_after = 1'b1; end
            UC_AW'(21): begin u.scl = SCL_LO; u.last = 1'b1; end
            // nack: SDA released high for the clock pulse
            UC_AW'(22): begin
                u.own        = OWN_CLR;
                u.sda        = SDA_HI;
                u.scl        = SCL_LO;
                u.wait_after = 1'b1;
            end
            UC_AW'(23): begin u.scl = SCL_HI; u.wait_after = 1'b1; end
            UC_AW'(24): begin u.scl = SCL_LO; u.last = 1'b1; end
            default:    begin u.last = 1'b1; end
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/i2cmbs_cfg.sv =====
// ----------------------------------------------------------------------------
// i2cmbs_cfg
// APB register slice holding the wait length; zero is stored as one.
// ----------------------------------------------------------------------------
module i2cmbs_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cmbs_pkg::CFG_AW-1:0]    paddr,
    input  logic [i2cmbs_pkg::CFG_DW-1:0]    pwdata,
    output logic [i2cmbs_pkg::CFG_DW-1:0]    prdata,
    output logic                             pready
);
    import i2cmbs_pkg::*;

    logic [WAIT_W-1:0]   r_wait;
    logic [WAIT_W-1:0]   n_wait;
    logic [CFG_AW-3:0]   reg_idx;
    logic                wr_en;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_WAIT_CYCLES);
    assign pready  = 1'b1;

    always_comb begin
        n_wait = r_wait;
        if (wr_en) begin
            n_wait = (pwdata[WAIT_W-1:0] == '0) ? WAIT_MIN : pwdata[WAIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= WAIT_RESET;
        end else begin
            r_wait <= n_wait;
        end
    end

    assign prdata = (reg_idx == REG_WAIT_CYCLES) ? CFG_DW'(r_wait) : '0;

endmodule

// ===== rtl/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Microcoded I2C master bit engine: one command in, a run of line phases out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one command per transfer:
//   opcode, write_byte and bus_bits (SDA samples, MSB first; bit 0 for ack).
//   Output channel (o_valid / i_stall) carries one line phase per transfer:
//   SCL level, SDA drive/level, wait flag, read byte, ack flag, last marker.
//   Phases per command: start 4, stop 4, write 25, read 17, wait-ack 3,
//   ack 4, nack 3; opcode 7 is dropped and emits nothing.
//   Throughput: one phase per cycle while the receiver does not stall; the
//   microcode step counter is the pacing element. The first phase is
//   registered after the command has loaded the step counter; o_stall is
//   high while a command is running, and the next command is taken as soon
//   as its last phase has been produced (even if that phase still waits
//   at the output).
//   A stalled receiver freezes the step counter; the phase stays on the port.
//   Reset: SCL and SDA latch high, SDA released, no command in flight,
//   wait length 144. The wait length is written and read back over the APB
//   port; the sequencer itself does not use it to pace its phases.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [2:0]                       i_opcode,
    input  logic [i2cmbs_pkg::BYTE_BITS-1:0] i_write_byte,
    input  logic [i2cmbs_pkg::BYTE_BITS-1:0] i_bus_bits,
    // phase channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_scl_level,
    output logic                             o_sda_drive,
    output logic                             o_sda_level,
    output logic                             o_wait_after,
    output logic [i2cmbs_pkg::BYTE_BITS-1:0] o_read_data,
    output logic                             o_ack_ok,
    output logic                             o_last,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cmbs_pkg::CFG_AW-1:0]    paddr,
    input  logic [i2cmbs_pkg::CFG_DW-1:0]    pwdata,
    output logic [i2cmbs_pkg::CFG_DW-1:0]    prdata,
    output logic                             pready
);
    import i2cmbs_pkg::*;

    i2cmbs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // sequencer control
    logic                 r_busy;
    logic [UC_AW-1:0]     r_pc;
    logic [BIT_CW-1:0]    r_bit;
    logic                 r_out_valid;
    // command operands, shifted MSB first as bits are used
    logic [BYTE_BITS-1:0] r_wb;
    logic [BYTE_BITS-1:0] r_bus;
    // bus line state; also drives the level outputs of the current phase
    logic                 r_scl;
    logic                 r_sda;
    logic                 r_own;
    logic [BYTE_BITS-1:0] r_shift;
    // per-phase flags
    logic                 r_wait_after;
    logic                 r_last;
    logic [BYTE_BITS-1:0] r_rd;
    logic                 r_ack;

    logic                 n_scl;
    logic                 n_sda;
    logic                 n_own;
    logic [BYTE_BITS-1:0] n_shift;
    logic                 n_wait_after;
    logic                 n_last;

    t_ucode               uc;
    logic                 accept;
    logic                 step;
    logic                 loop_back;
    logic                 cmd_done;

    assign accept    = i_valid && !r_busy;
    assign step      = r_busy && (!r_out_valid || !i_stall);
    assign uc        = f_ucode(r_pc);
    // a loop step repeats until the last bit of the byte
    assign loop_back = uc.loop && (r_bit != BIT_CW'(BYTE_BITS - 1));
    assign cmd_done  = uc.last || (uc.loop && !loop_back);

    // datapath driven by the control word
    always_comb begin
        n_scl = r_scl;
        case (uc.scl)
            SCL_LO:  n_scl = 1'b0;
            SCL_HI:  n_scl = 1'b1;
            default: n_scl = r_scl;
        endcase

        n_sda = r_sda;
        case (uc.sda)
            SDA_LO:  n_sda = 1'b0;
            SDA_HI:  n_sda = 1'b1;
            SDA_BIT: n_sda = r_wb[BYTE_BITS-1];
            default: n_sda = r_sda;
        endcase

        n_own = r_own;
        case (uc.own)
            OWN_SET: n_own = 1'b1;
            OWN_CLR: n_own = 1'b0;
            default: n_own = r_own;
        endcase

        n_shift = r_shift;
        if (uc.shift_clr) begin
            n_shift = '0;
        end else if (uc.shift_in) begin
            n_shift = {r_shift[BYTE_BITS-2:0], r_bus[BYTE_BITS-1]};
        end

        // loop steps wait between bits and end the command after the last
        n_wait_after = uc.loop ? loop_back : uc.wait_after;
        n_last       = cmd_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pc         <= '0;
            r_bit        <= '0;
            r_out_valid  <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_own        <= 1'b0;
            r_shift      <= '0;
            r_wait_after <= 1'b0;
            r_last       <= 1'b0;
            r_rd         <= '0;
            r_ack        <= 1'b0;
        end else begin
            if (accept) begin
                // unused opcode is taken and dropped
                r_busy <= (t_opcode'(i_opcode) != OP_NONE);
                r_pc   <= f_entry(t_opcode'(i_opcode));
                r_bit  <= '0;
                r_wb   <= i_write_byte;
                r_bus  <= i_bus_bits;
            end

            if (step) begin
                r_out_valid  <= 1'b1;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_own        <= n_own;
                r_shift      <= n_shift;
                r_wait_after <= n_wait_after;
                r_last       <= n_last;
                r_rd         <= (uc.rd_out && cmd_done) ? n_shift : '0;
                r_ack        <= uc.ack_out && !r_bus[0];

                if (uc.shift_in) begin
                    r_bus <= {r_bus[BYTE_BITS-2:0], 1'b0};
                end

                if (cmd_done) begin
                    r_busy <= 1'b0;
                end else if (loop_back) begin
                    r_pc  <= uc.target;
                    r_bit <= r_bit + BIT_CW'(1);
                    r_wb  <= {r_wb[BYTE_BITS-2:0], 1'b0};
                end else begin
                    r_pc <= r_pc + UC_AW'(1);
                end
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall      = r_busy;
    assign o_valid      = r_out_valid;
    assign o_scl_level  = r_scl;
    assign o_sda_drive  = r_own;
    assign o_sda_level  = r_own ? r_sda : 1'b1;
    assign o_wait_after = r_wait_after;
    assign o_read_data  = r_rd;
    assign o_ack_ok     = r_ack;
    assign o_last       = r_last;

endmodule

// ===== tb/i2cmbs_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbs_tb_pkg
// Line phase predictor and scoreboard for the I2C master bit engine bench.
// ----------------------------------------------------------------------------
package i2cmbs_tb_pkg;

    import i2cmbs_pkg::*;

    typedef struct packed {
        logic                 scl;
        logic                 drive;
        logic                 level;
        logic                 hold;
        logic [BYTE_BITS-1:0] rd;
        logic                 ack;
        logic                 fin;
    } t_line_phase;

    class phase_scoreboard;
        t_line_phase          expected_phases[$];
        logic                 scl_line;
        logic                 sda_line;
        logic                 sda_owned;
        logic [BYTE_BITS-1:0] shift_reg;
        logic [WAIT_W-1:0]    hold_len;
        int                   mismatches;
        int                   commands;
        int                   dropped;
        int                   phases_checked;
        int                   reg_writes;

        function new();
            scl_line       = 1'b1;
            sda_line       = 1'b1;
            sda_owned      = 1'b0;
            shift_reg      = '0;
            hold_len       = WAIT_RESET;
            mismatches     = 0;
            commands       = 0;
            dropped        = 0;
            phases_checked = 0;
            reg_writes     = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        function int pending();
            return expected_phases.size();
        endfunction

        // released SDA reads back as the pull-up level
        function void push_phase(logic hold, logic fin, logic [BYTE_BITS-1:0] rd, logic ack);
            t_line_phase p;
            p.scl   = scl_line;
            p.drive = sda_owned;
            p.level = sda_owned ? sda_line : 1'b1;
            p.hold  = hold;
            p.rd    = rd;
            p.ack   = ack;
            p.fin   = fin;
            expected_phases.push_back(p);
        endfunction

        function void note_command(t_opcode op, logic [BYTE_BITS-1:0] wb,
                                   logic [BYTE_BITS-1:0] bus);
            bit fin;
            if (op == OP_NONE) begin
                dropped++;
                return;
            end
            commands++;
            case (op)
                OP_START: begin
                    sda_owned = 1'b1;
                    sda_line = 1'b1; push_phase(0, 0, '0, 0);
                    scl_line = 1'b1; push_phase(1, 0, '0, 0);
                    sda_line = 1'b0; push_phase(1, 0, '0, 0);
                    scl_line = 1'b0; push_phase(0, 1, '0, 0);
                end
                OP_STOP: begin
                    sda_owned = 1'b1;
                    sda_line = 1'b0; push_phase(0, 0, '0, 0);
                    scl_line = 1'b0; push_phase(1, 0, '0, 0);
                    scl_line = 1'b1; push_phase(1, 0, '0, 0);
                    sda_line = 1'b1; push_phase(0, 1, '0, 0);
                end
                OP_WRITE: begin
                    sda_owned = 1'b1;
                    scl_line = 1'b0; push_phase(1, 0, '0, 0);
                    for (int i = 0; i < BYTE_BITS; i++) begin
                        fin = (i == BYTE_BITS - 1);
                        sda_line = wb[BYTE_BITS-1-i]; push_phase(1, 0, '0, 0);
                        scl_line = 1'b1;              push_phase(1, 0, '0, 0);
                        scl_line = 1'b0;              push_phase(!fin, fin, '0, 0);
                    end
                end
                OP_READ: begin
                    sda_owned = 1'b0;
                    push_phase(1, 0, '0, 0);
                    shift_reg = '0;
                    for (int i = 0; i < BYTE_BITS; i++) begin
                        fin = (i == BYTE_BITS - 1);
                        scl_line = 1'b1; push_phase(1, 0, '0, 0);
                        shift_reg = {shift_reg[BYTE_BITS-2:0], bus[BYTE_BITS-1-i]};
                        scl_line = 1'b0;
                        push_phase(!fin, fin, fin ? shift_reg : '0, 0);
                    end
                end
                OP_WAITACK: begin
                    sda_owned = 1'b0;
                    sda_line = 1'b1; push_phase(0, 0, '0, 0);
                    scl_line = 1'b1; push_phase(1, 0, '0, 0);
                    scl_line = 1'b0; push_phase(0, 1, '0, !bus[0]);
                end
                OP_ACK: begin
                    sda_owned = 1'b1;
                    scl_line = 1'b0; push_phase(0, 0, '0, 0);
                    sda_line = 1'b0; push_phase(1, 0, '0, 0);
                    scl_line = 1'b1; push_phase(1, 0, '0, 0);
                    scl_line = 1'b0; push_phase(0, 1, '0, 0);
                end
                OP_NACK: begin
                    sda_owned = 1'b0;
                    sda_line  = 1'b1;
                    scl_line = 1'b0; push_phase(1, 0, '0, 0);
                    scl_line = 1'b1; push_phase(1, 0, '0, 0);
                    scl_line = 1'b0; push_phase(0, 1, '0, 0);
                end
                default: ;
            endcase
        endfunction

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_phase(t_line_phase got);
            t_line_phase want;
            if (expected_phases.size() == 0) begin
                report("line phase with no command pending");
                return;
            end
            want = expected_phases.pop_front();
            phases_checked++;
            compare_field("scl_level",  got.scl,   want.scl);
            compare_field("sda_drive",  got.drive, want.drive);
            compare_field("sda_level",  got.level, want.level);
            compare_field("wait_after", got.hold,  want.hold);
            compare_field("read_data",  got.rd,    want.rd);
            compare_field("ack_ok",     got.ack,   want.ack);
            compare_field("last",       got.fin,   want.fin);
        endtask

        // zero is stored as the minimum of one; other indexes are ignored
        function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
            reg_writes++;
            if (addr[CFG_AW-1:2] == REG_WAIT_CYCLES) begin
                hold_len = data[WAIT_W-1:0];
                if (hold_len == '0)
                    hold_len = WAIT_MIN;
            end
        endfunction

        task check_wait_readback(logic [CFG_DW-1:0] data);
            compare_field("wait_cycles readback", data[WAIT_W-1:0], hold_len);
        endtask
    endclass

endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for i2c_master_bit_sequencer: drives bus commands and
// APB register accesses, predicts every SCL/SDA line phase and compares it.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cmbs_pkg::*;
    import i2cmbs_tb_pkg::*;

    localparam int RUN_LIMIT   = 500000;   // cycles before the run is declared hung
    localparam int DRAIN       = 40;       // settle time after the last phase
    localparam int HOLD_CYCLES = 400;      // long output hold-off
    localparam int ITEMS_PER_PROFILE = 150;

    localparam logic [CFG_AW-1:0] ADDR_WAIT  = {REG_WAIT_CYCLES, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_SPARE = CFG_AW'(4);

    // ------------------------------------------------------------------
    // clock, block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic [2:0]           i_opcode     = '0;
    logic [BYTE_BITS-1:0] i_write_byte = '0;
    logic [BYTE_BITS-1:0] i_bus_bits   = '0;
    logic                 i_stall      = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [CFG_AW-1:0]    paddr        = '0;
    logic [CFG_DW-1:0]    pwdata       = '0;

    logic                 o_stall;
    logic                 o_valid;
    logic                 o_scl_level;
    logic                 o_sda_drive;
    logic                 o_sda_level;
    logic                 o_wait_after;
    logic [BYTE_BITS-1:0] o_read_data;
    logic                 o_ack_ok;
    logic                 o_last;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;

    // idle profile, percent of cycles
    int send_gap_pct = 0;
    int stall_pct    = 0;

    logic hold_request = 1'b0;
    logic hold_off     = 1'b0;

    int cycle_count = 0;
    int items_sent  = 0;

    phase_scoreboard sb;

    always #1 i_clk = ~i_clk;

    i2c_master_bit_sequencer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_write_byte (i_write_byte),
        .i_bus_bits   (i_bus_bits),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_scl_level  (o_scl_level),
        .o_sda_drive  (o_sda_drive),
        .o_sda_level  (o_sda_level),
        .o_wait_after (o_wait_after),
        .o_read_data  (o_read_data),
        .o_ack_ok     (o_ack_ok),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Run hung after %0d cycles, %0d phases still expected",
                     cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the same edge, pre-edge values.
    // A command is noted before any phase is checked; its own first phase
    // can't leave the block in the cycle it is accepted anyway.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_line_phase got;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_command(t_opcode'(i_opcode), i_write_byte, i_bus_bits);
            if (o_valid && !i_stall) begin
                got = '{o_scl_level, o_sda_drive, o_sda_level, o_wait_after,
                        o_read_data, o_ack_ok, o_last};
                sb.check_phase(got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall per cycle, forced high during the hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // long hold-off, counted here so the sender keeps offering commands
    // and the block backs up into o_stall
    initial begin : hold_off_ctl
        int n;
        wait (hold_request);
        @(posedge i_clk);
        hold_off <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Command transfer: optional gap, then hold the payload until taken.
    // valid stays high back to back when no gap is drawn.
    // ------------------------------------------------------------------
    task send_command(t_opcode op, logic [BYTE_BITS-1:0] wb, logic [BYTE_BITS-1:0] bus);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_write_byte <= wb;
        i_bus_bits   <= bus;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // ------------------------------------------------------------------
    // APB accesses: setup cycle, then access until pready, then psel is
    // dropped before the next access
    // ------------------------------------------------------------------
    task apb_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task check_wait_reg();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WAIT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.check_wait_readback(prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, let every predicted phase out, then let a dropped
    // command settle before touching the register
    task wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // One bus transaction: start, address, ack, data bytes, stop.
    // Direction comes from the address LSB; stop is sometimes skipped so
    // the next start becomes a repeated start.
    // ------------------------------------------------------------------
    task run_transaction();
        logic [BYTE_BITS-1:0] addr;
        int                   nbytes;
        int                   k;
        addr   = 8'($urandom);
        nbytes = $urandom_range(3);
        send_command(OP_START, 8'($urandom), 8'($urandom));
        send_command(OP_WRITE, addr, 8'($urandom));
        send_command(OP_WAITACK, 8'($urandom), 8'($urandom));
        for (k = 0; k < nbytes; k++) begin
            if (addr[0]) begin
                send_command(OP_READ, 8'($urandom), 8'($urandom));
                send_command((k == nbytes - 1) ? OP_NACK : OP_ACK,
                             8'($urandom), 8'($urandom));
            end else begin
                send_command(OP_WRITE, 8'($urandom), 8'($urandom));
                send_command(OP_WAITACK, 8'($urandom), 8'($urandom));
            end
        end
        if ($urandom_range(99) < 80)
            send_command(OP_STOP, 8'($urandom), 8'($urandom));
    endtask

    // mostly well-formed transactions, the rest stray commands incl. opcode 7
    task run_random(int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal) begin
            if ($urandom_range(99) < 85)
                run_transaction();
            else
                send_command(t_opcode'($urandom_range(7)), 8'($urandom), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of the wait length
        check_wait_reg();

        // directed: every opcode, byte extremes, ack and nack answers,
        // dropped opcode right after reset and between commands
        send_command(OP_NONE,    8'hFF, 8'hFF);
        send_command(OP_START,   8'h00, 8'h00);
        send_command(OP_WRITE,   8'hFF, 8'h00);
        send_command(OP_WAITACK, 8'h00, 8'hFE);   // SDA low: acknowledged
        send_command(OP_WRITE,   8'h00, 8'hFF);
        send_command(OP_WAITACK, 8'hFF, 8'h01);   // SDA high: no acknowledge
        send_command(OP_WRITE,   8'hA5, 8'h5A);
        send_command(OP_WRITE,   8'h80, 8'h01);
        send_command(OP_WRITE,   8'h01, 8'h80);
        send_command(OP_READ,    8'hFF, 8'h00);
        send_command(OP_ACK,     8'h00, 8'h00);
        send_command(OP_READ,    8'h00, 8'hFF);
        send_command(OP_ACK,     8'hFF, 8'hFF);
        send_command(OP_READ,    8'h3C, 8'h5A);
        send_command(OP_NACK,    8'hFF, 8'h00);   // SDA released high on the pulse
        send_command(OP_NONE,    8'h00, 8'h00);
        send_command(OP_STOP,    8'hFF, 8'hFF);
        send_command(OP_WAITACK, 8'h55, 8'h00);
        send_command(OP_NACK,    8'hAA, 8'hFF);
        send_command(OP_ACK,     8'h0F, 8'hF0);
        send_command(OP_READ,    8'hF0, 8'h81);
        send_command(OP_STOP,    8'h00, 8'h00);
        wait_idle();

        // profile 1: sender mostly busy, receiver stalls a lot; shortest wait
        apb_write(ADDR_WAIT, {16'($urandom), 16'd1});
        check_wait_reg();
        send_gap_pct = 8;
        stall_pct    = 77;
        run_random(ITEMS_PER_PROFILE);
        wait_idle();

        // profile 2: the other way round; longest wait, then a write to an
        // unmapped index that must leave the wait length alone
        apb_write(ADDR_WAIT, {16'($urandom), 16'hFFFF});
        check_wait_reg();
        apb_write(ADDR_SPARE, $urandom);
        check_wait_reg();
        send_gap_pct = 77;
        stall_pct    = 8;
        run_random(ITEMS_PER_PROFILE);
        wait_idle();

        // profile 3: no idling, with the long output hold-off at its start;
        // zero wait reads back as the minimum
        apb_write(ADDR_WAIT, {16'($urandom), 16'd0});
        check_wait_reg();
        apb_write(ADDR_WAIT, {16'($urandom), 16'($urandom_range(2, 65534))});
        check_wait_reg();
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        run_random(ITEMS_PER_PROFILE);
        wait_idle();

        $display("Run covered %0d commands (%0d dropped) and %0d checked line phases",
                 sb.commands, sb.dropped, sb.phases_checked);
        $display("over three idle profiles, a %0d-cycle output hold-off and %0d register writes",
                 HOLD_CYCLES, sb.reg_writes);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
